// ===== sv/ubsd_pkg.sv =====
// Shared types and constants for the UTF byte stream decoder.
`default_nettype none
package ubsd_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef logic [1:0] width_code_t;
  localparam width_code_t CW_UTF8  = 2'd0;
  localparam width_code_t CW_UTF16 = 2'd1;
  localparam width_code_t CW_UTF32 = 2'd2;
  localparam width_code_t CW_NONE  = 2'd3;

  typedef logic reg_idx_t;
  localparam reg_idx_t REG_WIDTH_CODE = 1'b0;
  localparam reg_idx_t REG_ENDIAN     = 1'b1;

  localparam logic KIND_CODE_POINT = 1'b0;
  localparam logic KIND_RAW        = 1'b1;

  localparam logic [7:0]  LEAD_CONT_LIMIT = 8'hC0;
  localparam logic [7:0]  ASCII_LIMIT     = 8'h80;
  localparam logic [7:0]  LEAD3_BASE      = 8'hE0;
  localparam logic [7:0]  LEAD4_BASE      = 8'hF0;
  localparam logic [7:0]  LEAD_BAD_BASE   = 8'hF8;
  localparam logic [1:0]  CONT_TAG        = 2'b10;
  localparam logic [15:0] HI_SURR_LOW     = 16'hD800;
  localparam logic [15:0] HI_SURR_HIGH    = 16'hDBFF;
  localparam logic [15:0] LO_SURR_LOW     = 16'hDC00;
  localparam logic [15:0] LO_SURR_HIGH    = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;
  localparam logic [31:0] CODE_POINT_MAX  = 32'h0010FFFF;

  typedef struct packed {
    width_code_t width_code;
    logic        little_endian;
    logic        wr;
  } cfg_t;

  // One decoded item: a single code point or up to four raw bytes.
  typedef struct packed {
    logic [2:0]      cnt;
    logic            raw;
    logic [20:0]     cp;
    logic [3:0][7:0] bytes;
  } group_t;

endpackage
`default_nettype wire

// ===== sv/ubsd_ifs.sv =====
// Valid/ready channel interfaces for input bytes and decoded results.
`default_nettype none
interface ubsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;
  modport source(output valid, output data_byte, output end_of_string, input ready);
  modport sink(input valid, input data_byte, input end_of_string, output ready);
endinterface

interface ubsd_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [20:0] result_value;
  logic        last_of_run;
  modport source(output valid, output result_kind, output result_value,
                 output last_of_run, input ready);
  modport sink(input valid, input result_kind, input result_value,
               input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/ubsd_cfg.sv =====
// APB-style register port holding the width code and byte order.
`default_nettype none
module ubsd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ubsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ubsd_pkg::DATA_W-1:0] pwdata,
  output      logic [ubsd_pkg::DATA_W-1:0] prdata,
  output      logic                       pready,
  output      ubsd_pkg::cfg_t             cfg
);
  import ubsd_pkg::*;

  width_code_t width_code;
  logic        little_endian;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_code    <= CW_UTF8;
      little_endian <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH_CODE: width_code    <= pwdata[1:0];
        REG_ENDIAN:     little_endian <= pwdata[0];
        default:        width_code    <= width_code;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH_CODE: prdata = {{(DATA_W-2){1'b0}}, width_code};
      REG_ENDIAN:     prdata = {{(DATA_W-1){1'b0}}, little_endian};
      default:        prdata = '0;
    endcase
  end

  assign cfg.width_code    = width_code;
  assign cfg.little_endian = little_endian;
  assign cfg.wr            = wr_en;

endmodule
`default_nettype wire

// ===== sv/ubsd_decode.sv =====
// Input register, unit state and single-pass decode into a result group.
`default_nettype none
module ubsd_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ubsd_pkg::cfg_t   cfg,
  input  wire logic             in_fire,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_eos,
  output      logic             busy,
  output      logic             grp_valid,
  output      ubsd_pkg::group_t grp
);
  import ubsd_pkg::*;

  logic            stage_valid;
  logic [7:0]      s_byte;
  logic            s_eos;
  logic [1:0]      held_count;
  logic [1:0]      held_count_next;
  logic [2:0]      unit_length;
  logic [2:0]      unit_length_next;
  logic [7:0]      held_bytes [3];
  logic            hb_we;

  logic [3:0][7:0] bufb;
  logic [2:0]      n;
  logic            cont_ok;
  logic [20:0]     utf8_val;
  logic [15:0]     hi16;
  logic [15:0]     lo16;
  logic [31:0]     w32;
  logic            hi_is_high;
  logic            hi_is_low;
  logic            lo_is_low;
  group_t          fin;
  group_t          raw_n;

  assign busy = stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      held_count  <= '0;
      unit_length <= '0;
    end else begin
      stage_valid <= in_fire;
      if (cfg.wr) begin
        held_count  <= '0;
        unit_length <= '0;
      end else if (stage_valid) begin
        held_count  <= held_count_next;
        unit_length <= unit_length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_byte <= in_byte;
      s_eos  <= in_eos;
    end
    if (stage_valid && hb_we) begin
      held_bytes[held_count] <= s_byte;
    end
  end

  // Assemble the unit and evaluate every completion check.
  always_comb begin
    bufb = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < held_count) bufb[i] = held_bytes[i];
    end
    bufb[held_count] = s_byte;
    n = {1'b0, held_count} + 3'd1;

    cont_ok = 1'b1;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < n && bufb[i][7:6] != CONT_TAG) cont_ok = 1'b0;
    end

    unique case (n)
      3'd2:    utf8_val = {10'b0, bufb[0][4:0], bufb[1][5:0]};
      3'd3:    utf8_val = {5'b0, bufb[0][3:0], bufb[1][5:0], bufb[2][5:0]};
      default: utf8_val = {bufb[0][2:0], bufb[1][5:0], bufb[2][5:0], bufb[3][5:0]};
    endcase

    hi16 = cfg.little_endian ? {bufb[1], bufb[0]} : {bufb[0], bufb[1]};
    lo16 = cfg.little_endian ? {bufb[3], bufb[2]} : {bufb[2], bufb[3]};
    w32  = cfg.little_endian ? {bufb[3], bufb[2], bufb[1], bufb[0]}
                             : {bufb[0], bufb[1], bufb[2], bufb[3]};
    hi_is_high = hi16 >= HI_SURR_LOW && hi16 <= HI_SURR_HIGH;
    hi_is_low  = hi16 >= LO_SURR_LOW && hi16 <= LO_SURR_HIGH;
    lo_is_low  = lo16 >= LO_SURR_LOW && lo16 <= LO_SURR_HIGH;

    raw_n.cnt   = n;
    raw_n.raw   = KIND_RAW;
    raw_n.cp    = '0;
    raw_n.bytes = bufb;

    fin     = raw_n;
    fin.cnt = 3'd1;
    unique case (cfg.width_code)
      CW_UTF8: begin
        if (cont_ok) begin
          fin.raw = KIND_CODE_POINT;
          fin.cp  = utf8_val;
        end else begin
          fin = raw_n;
        end
      end
      CW_UTF16: begin
        if (n != 3'd4) begin
          if (hi_is_low) begin
            fin = raw_n;
          end else begin
            fin.raw = KIND_CODE_POINT;
            fin.cp  = {5'b0, hi16};
          end
        end else if (lo_is_low) begin
          fin.raw = KIND_CODE_POINT;
          fin.cp  = SUPP_BASE + {1'b0, hi16[9:0], lo16[9:0]};
        end else begin
          fin = raw_n;
        end
      end
      default: begin
        if (w32 > CODE_POINT_MAX) begin
          fin = raw_n;
        end else begin
          fin.raw = KIND_CODE_POINT;
          fin.cp  = w32[20:0];
        end
      end
    endcase
  end

  // Choose between immediate result, completion, hold and flush.
  always_comb begin
    logic       done;
    logic [2:0] eff_len;
    logic       surr_wait;

    done             = 1'b0;
    eff_len          = unit_length;
    surr_wait        = 1'b0;
    grp_valid        = 1'b0;
    grp              = raw_n;
    grp.cnt          = 3'd1;
    grp.bytes[0]     = s_byte;
    held_count_next  = '0;
    unit_length_next = '0;
    hb_we            = 1'b0;

    if (cfg.width_code == CW_NONE) begin
      done = 1'b1;
    end else if (held_count == 2'd0) begin
      if (cfg.width_code == CW_UTF8) begin
        priority if (s_byte < ASCII_LIMIT) begin
          done    = 1'b1;
          grp.raw = KIND_CODE_POINT;
          grp.cp  = {13'b0, s_byte};
        end else if (s_byte < LEAD_CONT_LIMIT || s_byte >= LEAD_BAD_BASE) begin
          done = 1'b1;
        end else if (s_byte < LEAD3_BASE) begin
          eff_len = 3'd2;
        end else if (s_byte < LEAD4_BASE) begin
          eff_len = 3'd3;
        end else begin
          eff_len = 3'd4;
        end
      end else if (cfg.width_code == CW_UTF16) begin
        eff_len = 3'd2;
      end else begin
        eff_len = 3'd4;
      end
    end

    surr_wait = cfg.width_code == CW_UTF16 && n == 3'd2 && hi_is_high;

    if (done) begin
      grp_valid = stage_valid;
    end else if (n >= eff_len && !surr_wait) begin
      grp_valid = stage_valid;
      grp       = fin;
    end else if (s_eos) begin
      grp_valid = stage_valid;
      grp       = raw_n;
    end else begin
      hb_we            = 1'b1;
      held_count_next  = n[1:0];
      unit_length_next = surr_wait ? 3'd4 : eff_len;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ubsd_group_fifo.sv =====
// Queue of result groups, unrolled into single results on the output channel.
`default_nettype none
module ubsd_group_fifo #(
  parameter int DEPTH = 4,
  parameter int CNT_W = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ubsd_pkg::group_t push_grp,
  output      logic [CNT_W-1:0] count,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic             out_kind,
  output      logic [20:0]      out_value,
  output      logic             out_last
);
  import ubsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  group_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [1:0]       sub;
  group_t           head;
  logic             pop;
  logic             adv;

  assign head      = mem[rd_ptr];
  assign out_valid = count != '0;
  assign out_kind  = head.raw;
  assign out_value = head.raw ? {13'b0, head.bytes[sub]} : head.cp;
  assign out_last  = head.raw ? (({1'b0, sub} + 3'd1) == head.cnt) : 1'b1;
  assign adv       = out_valid && out_ready;
  assign pop       = adv && out_last;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      sub    <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        sub    <= '0;
      end else if (adv) begin
        sub <= sub + 2'd1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== sv/utf_byte_stream_decoder_top.sv =====
// Top level of the UTF-8/16/32 byte stream decoder.
//
//   channel       role    carries
//   byte_chan     sink    data_byte, end_of_string
//   result_chan   source  result_kind, result_value, last_of_run
//   APB port      slave   char_width_code at 0x0, little_endian at 0x4
//
// One byte is taken per cycle while ready is high; a group that it completes
// is pushed to the group queue from the input stage register. Results leave
// one per cycle while result ready is high, a failed four-byte unit as four
// raw results; queue depth sets how far input leads output before ready drops.
// Reset is synchronous and clears unit state, queue and registers.
`default_nettype none
module utf_byte_stream_decoder_top #(
  parameter int GROUP_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ubsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ubsd_pkg::DATA_W-1:0] pwdata,
  output      logic [ubsd_pkg::DATA_W-1:0] prdata,
  output      logic                        pready,
  ubsd_byte_if.sink                        byte_chan,
  ubsd_result_if.source                    result_chan
);
  import ubsd_pkg::*;

  localparam int CNT_W = $clog2(GROUP_DEPTH + 1);

  cfg_t             cfg;
  logic             byte_fire;
  logic             stage_busy;
  logic             grp_valid;
  group_t           grp;
  logic [CNT_W-1:0] grp_count;

  assign byte_chan.ready = ({1'b0, grp_count} + {{CNT_W{1'b0}}, stage_busy})
                           < (CNT_W + 1)'(GROUP_DEPTH);
  assign byte_fire = byte_chan.valid && byte_chan.ready;

  ubsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ubsd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (byte_fire),
    .in_byte   (byte_chan.data_byte),
    .in_eos    (byte_chan.end_of_string),
    .busy      (stage_busy),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  ubsd_group_fifo #(
    .DEPTH (GROUP_DEPTH),
    .CNT_W (CNT_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (grp_valid),
    .push_grp  (grp),
    .count     (grp_count),
    .out_valid (result_chan.valid),
    .out_ready (result_chan.ready),
    .out_kind  (result_chan.result_kind),
    .out_value (result_chan.result_value),
    .out_last  (result_chan.last_of_run)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    grp_count <= CNT_W'(GROUP_DEPTH))
    else $error("group queue overflow");

  a_stage_load: assert property (@(posedge clk) disable iff (rst)
    byte_fire |=> stage_busy)
    else $error("accepted byte not staged");

  a_code_point_last: assert property (@(posedge clk) disable iff (rst)
    (result_chan.valid && result_chan.result_kind == KIND_CODE_POINT)
      |-> result_chan.last_of_run)
    else $error("code point not last of run");

  a_raw_narrow: assert property (@(posedge clk) disable iff (rst)
    (result_chan.valid && result_chan.result_kind == KIND_RAW)
      |-> result_chan.result_value[20:8] == '0)
    else $error("raw result wider than a byte");
`endif

endmodule
`default_nettype wire
